// ===== hdl/iprl_pkg.sv =====
// ----------------------------------------------------------------------------
// iprl_pkg
// Shared types and constants for the IPv4 range region lookup block.
// ----------------------------------------------------------------------------
package iprl_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(TABLE_ENTRIES);

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] last;
    logic [15:0] code;
  } range_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    range_entry_t     data;
  } tbl_wr_t;

endpackage

// ===== hdl/iprl_if.sv =====
// ----------------------------------------------------------------------------
// iprl request / response channels
// Valid/ready channels carrying one lookup or insert transaction each way.
// ----------------------------------------------------------------------------
interface iprl_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] address;
  logic [32:0] range_count;
  logic [15:0] region_code;

  modport source (output valid, func, address, range_count, region_code, input ready);
  modport sink   (input valid, func, address, range_count, region_code, output ready);
endinterface

interface iprl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_code;

  modport source (output valid, status, found_code, input ready);
  modport sink   (input valid, status, found_code, output ready);
endinterface

// ===== hdl/ip_range_region_lookup_core.sv =====
// ----------------------------------------------------------------------------
// ip_range_region_lookup_core
// IPv4 address range table with region code lookup.
// ----------------------------------------------------------------------------
// Each request transaction either inserts a range (first address, address
// count, region code) or looks up an address; every request gives exactly one
// response transaction. The table holds up to TABLE_ENTRIES ranges in a
// single-port-read memory that is scanned one entry per cycle through one
// compare unit, so every stored entry passes that unit, read through the
// registered memory read port, before the response is formed. One
// transaction is worked on at a time; a new request is taken as soon as the
// sequencer is idle, even while the previous response still waits. The
// table count is cleared by reset; the memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
module ip_range_region_lookup_core (
  input  logic        clk,
  input  logic        rst_n,
  iprl_req_if.sink    in_ch,
  iprl_rsp_if.source  out_ch
);
  import iprl_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;     // entries issued to the read port
  logic             rd_vld_r;           // read data valid this cycle
  logic [CNT_W-1:0] used_r;

  // captured request
  logic        func_r;
  logic [31:0] addr_r;
  logic [31:0] last_r;
  logic [15:0] code_r;

  // scan results
  logic        dup_r;
  logic        have_r;
  logic [31:0] best_start_r;
  logic [31:0] best_last_r;
  logic [15:0] best_code_r;

  // response register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [15:0] out_code_r;

  tbl_wr_t      tbl_wr;
  range_entry_t rd_data;

  logic        accept;
  logic        issue;
  logic        load_rsp;
  logic [32:0] cnt_eff;
  logic [33:0] last_sum;
  logic        start_le;
  logic        start_gt_best;

  iprl_store u_store (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_idx  (cnt_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // last = first + count - 1, count of zero taken as one, saturated
  assign cnt_eff  = (in_ch.range_count == 33'd0) ? 33'd1 : in_ch.range_count;
  assign last_sum = {2'b00, in_ch.address} + {1'b0, cnt_eff} - 34'd1;

  assign issue = (state_r == S_SCAN) && (cnt_r < used_r);

  // shared compare unit on the entry coming out of the memory
  assign start_le      = (rd_data.start <= addr_r);
  assign start_gt_best = (rd_data.start > best_start_r);

  // response can load when the output register is free or draining
  assign load_rsp = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  always_comb begin
    tbl_wr.en         = load_rsp && (func_r == FUNC_INSERT) && !dup_r
                        && (used_r != TABLE_FULL);
    tbl_wr.idx        = used_r[IDX_W-1:0];
    tbl_wr.data.start = addr_r;
    tbl_wr.data.last  = last_r;
    tbl_wr.data.code  = code_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_rsp) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= issue;
      if (tbl_wr.en) begin
        used_r <= used_r + CNT_W'(1);
      end
      if (load_rsp) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
      addr_r <= in_ch.address;
      code_r <= in_ch.region_code;
      last_r <= (last_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : last_sum[31:0];
      dup_r  <= 1'b0;
      have_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (func_r == FUNC_INSERT) begin
        if (rd_data.start == addr_r) begin
          dup_r <= 1'b1;
        end
      end else if (start_le && (!have_r || start_gt_best)) begin
        have_r       <= 1'b1;
        best_start_r <= rd_data.start;
        best_last_r  <= rd_data.last;
        best_code_r  <= rd_data.code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      out_code_r <= 16'd0;
      if (func_r == FUNC_INSERT) begin
        priority if (dup_r) begin
          out_status_r <= ST_DUP;
        end else if (used_r == TABLE_FULL) begin
          out_status_r <= ST_FULL;
        end else begin
          out_status_r <= ST_OK;
        end
      end else if (have_r && (addr_r <= best_last_r)) begin
        out_status_r <= ST_OK;
        out_code_r   <= best_code_r;
      end else begin
        out_status_r <= ST_MISS;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.found_code = out_code_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // a table write always goes with a successful insert response
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |=> out_valid_r && (out_status_r == ST_OK))
    else $error("table write without OK response");

  // fill count never passes the table size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= TABLE_FULL)
    else $error("entry count overflow");

  // memory reads only return during a scan
  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN))
    else $error("read data outside scan");

  // found code is zero unless the response is a hit
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_code_r == 16'd0))
    else $error("non-zero code on non-hit response");

endmodule

// ===== hdl/iprl_store.sv =====
// ----------------------------------------------------------------------------
// iprl_store
// Range table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module iprl_store (
  input  logic                         clk,
  input  iprl_pkg::tbl_wr_t            wr,
  input  logic [iprl_pkg::IDX_W-1:0]   rd_idx,
  output iprl_pkg::range_entry_t       rd_data
);
  import iprl_pkg::*;

  range_entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
  end

endmodule

// ===== bench/tb_ip_range_region_lookup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ip_range_region_lookup_core
// Self-checking bench for the IPv4 range region lookup core. Drives insert and
// lookup transactions over the request channel and keeps a local copy of the
// range table. Every response is checked against the predicted status and
// region code, in order.
// ----------------------------------------------------------------------------
module tb_ip_range_region_lookup_core;
  import iprl_pkg::*;

  // No transaction in either direction for this many cycles ends the run.
  // The slowest legal gap is a full-table scan behind the long receiver
  // hold-off below, so this leaves a wide margin.
  localparam int STALL_LIMIT   = 6000;
  localparam int HOLD_CYCLES   = 900;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] code;
  } iprl_result_t;

  logic clk;
  logic rst_n;

  iprl_req_if req_ch ();
  iprl_rsp_if rsp_ch ();

  ip_range_region_lookup_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // --------------------------------------------------------------------------
  // Local copy of the range table; only entries below tbl_count are valid.
  // --------------------------------------------------------------------------
  logic [31:0] tbl_start [TABLE_ENTRIES];
  logic [31:0] tbl_last  [TABLE_ENTRIES];
  logic [15:0] tbl_code  [TABLE_ENTRIES];
  int          tbl_count;

  iprl_result_t pending_results [$];
  int           fail_count = 0;

  // Idle control shared between the tests and the two channel processes
  logic tx_quiet;
  logic rx_quiet;
  int   hold_token;
  int   hold_len;

  // --------------------------------------------------------------------------
  // Clock: 8 ns period
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Predictor. Applies one accepted request to the local table and returns
  // the response it must produce.
  // --------------------------------------------------------------------------
  function automatic iprl_result_t predict_response(input logic        op,
                                                    input logic [31:0] addr,
                                                    input logic [32:0] cnt,
                                                    input logic [15:0] code);
    iprl_result_t res;
    logic [32:0]  n;
    logic [32:0]  last_wide;
    int           best;
    bit           found;
    res.status = ST_OK;
    res.code   = '0;
    best       = 0;
    found      = 1'b0;
    if (op == FUNC_INSERT) begin
      // duplicate start is checked ahead of the full table
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_start[i] == addr) begin
          res.status = ST_DUP;
          return res;
        end
      end
      if (tbl_count >= TABLE_ENTRIES) begin
        res.status = ST_FULL;
        return res;
      end
      // a zero count is taken as one address; the end saturates at the top
      n         = (cnt == '0) ? 33'd1 : cnt;
      last_wide = {1'b0, addr} + n - 33'd1;
      tbl_start[tbl_count] = addr;
      tbl_last[tbl_count]  = last_wide[32] ? 32'hFFFF_FFFF : last_wide[31:0];
      tbl_code[tbl_count]  = code;
      tbl_count++;
    end else begin
      // greatest start at or below the address
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_start[i] <= addr && (!found || tbl_start[i] > tbl_start[best])) begin
          best  = i;
          found = 1'b1;
        end
      end
      if (!found || addr > tbl_last[best])
        res.status = ST_MISS;
      else
        res.code = tbl_code[best];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random field generators
  // --------------------------------------------------------------------------
  function automatic logic [15:0] pick_code();
    if ($urandom_range(99) < 75)
      return {8'(65 + $urandom_range(25)), 8'(65 + $urandom_range(25))};
    return 16'($urandom());
  endfunction

  function automatic logic [32:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3)  return 33'd0;
    if (r < 8)  return 33'h1_0000_0000;
    if (r < 50) return 33'($urandom_range(256, 1));
    if (r < 80) return 33'($urandom_range(65536, 1));
    return {1'b0, 32'($urandom())};
  endfunction

  // Range starts: a dense block of /24 starts so that ranges overlap and
  // repeat, plus re-used starts, both ends of the address space and noise.
  function automatic logic [31:0] pick_start();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40)
      return {16'h0A00, 8'($urandom_range(255)), 8'h00};
    if (r < 55 && tbl_count != 0)
      return tbl_start[$urandom_range(tbl_count - 1)];
    if (r < 65)
      return 32'hFFFF_FF00 | 32'($urandom_range(255));
    if (r < 72)
      return 32'($urandom_range(255));
    return 32'($urandom());
  endfunction

  // Lookup addresses aimed at the edges of stored ranges
  function automatic logic [31:0] pick_probe();
    int unsigned r;
    int unsigned i;
    logic [31:0] s;
    logic [31:0] l;
    logic [63:0] span;
    r = $urandom_range(99);
    if (tbl_count == 0 || r < 15)
      return 32'($urandom());
    i = $urandom_range(tbl_count - 1);
    s = tbl_start[i];
    l = tbl_last[i];
    if (r < 30) return s;
    if (r < 45) return l;
    if (r < 60) return l + 32'd1;
    if (r < 70) return s - 32'd1;
    span = 64'(l - s) + 64'd1;
    return s + 32'({32'($urandom()), 32'($urandom())} % span);
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Valid is only lowered when a gap is taken, so back-to-back
  // transactions never see two assignments to valid in one step.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic        op,
                           input logic [31:0] addr,
                           input logic [32:0] cnt,
                           input logic [15:0] code);
    if (!tx_quiet) begin
      while ($urandom_range(99) < 30) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= op;
    req_ch.address     <= addr;
    req_ch.range_count <= cnt;
    req_ch.region_code <= code;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_response(op, addr, cnt, code));
  endtask

  task automatic send_random_insert();
    send_item(FUNC_INSERT, pick_start(), pick_count(), pick_code());
  endtask

  task automatic send_random_lookup();
    send_item(FUNC_LOOKUP, pick_probe(), pick_count(), pick_code());
  endtask

  task automatic release_sender();
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, with a counted hold-off on request
  // --------------------------------------------------------------------------
  int hold_seen;
  int hold_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      hold_seen    <= 0;
      hold_left    <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= hold_len;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= rx_quiet || ($urandom_range(99) >= 30);
    end
  end

  // --------------------------------------------------------------------------
  // Response checker: in-order compare against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_responses
    iprl_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected response: status %0d found_code %h",
               rsp_ch.status, rsp_ch.found_code);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.found_code !== want.code) begin
          $error("found_code: expected %h, actual %h", want.code, rsp_ch.found_code);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles with no transaction on either channel
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Lookups straight after reset: nothing is stored, so every one misses.
  // Ignored fields carry their extremes.
  task automatic test_empty_table();
    send_item(FUNC_LOOKUP, 32'h0000_0000, 33'h1_0000_0000, 16'hFFFF);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 33'd1, 16'h0000);
    send_item(FUNC_LOOKUP, 32'h0A00_0100, 33'h0_FFFF_FFFF, "ZZ");
  endtask

  // Hand-picked ranges around the edges of the behaviour
  task automatic test_directed_ranges();
    send_item(FUNC_INSERT, 32'h0A00_0100, 33'h100, "GB");
    // address below every stored start
    send_item(FUNC_LOOKUP, 32'h0A00_00FF, 33'd1, 16'h0000);
    send_item(FUNC_LOOKUP, 32'h0A00_0100, 33'd1, 16'h0000);
    send_item(FUNC_LOOKUP, 32'h0A00_01FF, 33'd1, 16'h0000);
    // one past the inclusive end
    send_item(FUNC_LOOKUP, 32'h0A00_0200, 33'd1, 16'h0000);
    // same start again is dropped
    send_item(FUNC_INSERT, 32'h0A00_0100, 33'd5, "FR");
    send_item(FUNC_LOOKUP, 32'h0A00_0104, 33'd1, 16'h0000);
    // lowest address, zero region code
    send_item(FUNC_INSERT, 32'h0000_0000, 33'd1, 16'h0000);
    send_item(FUNC_LOOKUP, 32'h0000_0000, 33'd1, 16'hFFFF);
    send_item(FUNC_LOOKUP, 32'h0000_0001, 33'd1, 16'hFFFF);
    // zero count gives a one-address range that shadows the wider one
    send_item(FUNC_INSERT, 32'h0A00_0180, 33'd0, "DE");
    send_item(FUNC_LOOKUP, 32'h0A00_0180, 33'd1, 16'h0000);
    send_item(FUNC_LOOKUP, 32'h0A00_0181, 33'd1, 16'h0000);
    // end saturates at the top of the address space
    send_item(FUNC_INSERT, 32'hFFFF_0000, 33'h1_0000_0000, 16'hFFFF);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 33'd1, 16'h0000);
    send_item(FUNC_INSERT, 32'hFFFF_FFFF, 33'd1, "US");
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 33'd1, 16'h0000);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFE, 33'd1, 16'h0000);
    send_item(FUNC_INSERT, 32'h8000_0000, 33'h0_FFFF_FFFF, "JP");
    send_item(FUNC_LOOKUP, 32'hC000_0000, 33'd1, 16'h0000);
    send_item(FUNC_LOOKUP, 32'h7FFF_FFFF, 33'd1, 16'h0000);
  endtask

  // Random mix until the table is full; the last inserts hit the full flag
  task automatic test_fill_table();
    while (tbl_count < TABLE_ENTRIES) begin
      if ($urandom_range(99) < 65)
        send_random_insert();
      else
        send_random_lookup();
    end
    repeat (6) send_random_insert();
  endtask

  // Receiver holds off while requests keep coming: the core takes one more,
  // parks its response, then must stall the request channel.
  task automatic test_output_backpressure();
    hold_len   = HOLD_CYCLES;
    hold_token = hold_token + 1;
    repeat (12) begin
      if ($urandom_range(1) == 0)
        send_random_insert();
      else
        send_random_lookup();
    end
  endtask

  // Sender goes quiet until every response is back, a few times over
  task automatic test_drain_pause();
    repeat (3) begin
      repeat (8) send_random_lookup();
      release_sender();
      wait_drain();
    end
  endtask

  // Long run on the full table; one stretch with no idling on either side
  task automatic test_full_table();
    for (int n = 0; n < 720; n++) begin
      tx_quiet = (n >= 200 && n < 320);
      rx_quiet = (n >= 200 && n < 320);
      if ($urandom_range(99) < 30)
        send_random_insert();
      else
        send_random_lookup();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_INSERT;
    req_ch.address     = '0;
    req_ch.range_count = '0;
    req_ch.region_code = '0;
    tbl_count          = 0;
    tx_quiet           = 1'b0;
    rx_quiet           = 1'b0;
    hold_token         = 0;
    hold_len           = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_directed_ranges();
    test_fill_table();
    test_output_backpressure();
    test_drain_pause();
    test_full_table();

    release_sender();
    wait_drain();
    // let any stray response show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/iprl_pkg.sv
hdl/iprl_if.sv
hdl/iprl_store.sv
hdl/ip_range_region_lookup_core.sv
bench/tb_ip_range_region_lookup_core.sv
